// ===== design/afe_pkg.sv =====
// ----------------------------------------------------------------------------
// afe_pkg
// Types, constants and saturating helpers shared by the field expansion block.
// ----------------------------------------------------------------------------
`default_nettype none

package afe_pkg;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EVAL = 1'b1;

   localparam logic [1:0] CSR_ORIGIN  = 2'd0;
   localparam logic [1:0] CSR_INVSTEP = 2'd1;
   localparam logic [1:0] CSR_ORDER   = 2'd2;
   localparam logic [1:0] CSR_NODES   = 2'd3;

   localparam logic signed [63:0] WIDE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

   localparam logic signed [9:0] STENCIL [6][7] = '{
      '{-10'sd1,   10'sd9,  -10'sd45,  10'sd0,   10'sd45, -10'sd9,  10'sd1},
      '{ 10'sd2,  -10'sd27,  10'sd270, -10'sd490, 10'sd270, -10'sd27, 10'sd2},
      '{ 10'sd1,  -10'sd8,   10'sd13,  10'sd0,  -10'sd13,  10'sd8, -10'sd1},
      '{-10'sd1,   10'sd12, -10'sd39,  10'sd56, -10'sd39,  10'sd12, -10'sd1},
      '{-10'sd1,   10'sd4,  -10'sd5,   10'sd0,   10'sd5,  -10'sd4,  10'sd1},
      '{ 10'sd1,  -10'sd6,   10'sd15, -10'sd20,  10'sd15, -10'sd6,  10'sd1}
   };
   localparam logic [11:0] STENCIL_DEN [6] = '{12'd60, 12'd180, 12'd8, 12'd6, 12'd2, 12'd1};
   localparam logic [11:0] SERIES_DIV [6] = '{12'd2, 12'd4, 12'd16, 12'd64, 12'd384, 12'd2304};
   localparam logic NEG_TERM [6] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

   typedef struct packed {
      logic               kind;
      logic [9:0]         sample_index;
      logic signed [31:0] sample_value;
      logic signed [31:0] axial_pos;
      logic signed [31:0] radial_pos;
   } item_type;

   typedef struct packed {
      logic signed [31:0] origin;
      logic [31:0]        inv_step;
      logic [2:0]         order;
      logic [10:0]        nodes;
   } cfg_type;

   typedef struct packed {
      logic               flag;
      logic signed [63:0] val;
   } sat_type;

   typedef struct packed {
      logic               flag;
      logic signed [31:0] val;
   } clip_type;

   typedef enum logic [3:0] {
      B_IDLE, B_POS, B_CELL, B_READ, B_IP, B_IPW, B_K0,
      B_ST, B_STW, B_DENW, B_SC, B_SCW, B_SDW, B_FIN
   } back_state_type;

   function automatic sat_type add_sat(input logic signed [63:0] a,
                                       input logic signed [63:0] b);
      logic signed [64:0] s;
      sat_type            res;
      s = 65'(a) + 65'(b);
      res.flag = 1'b0;
      res.val  = s[63:0];
      if (s > 65'(WIDE_MAX)) begin
         res.flag = 1'b1;
         res.val  = WIDE_MAX;
      end else if (s < -65'(WIDE_MAX)) begin
         res.flag = 1'b1;
         res.val  = -WIDE_MAX;
      end
      return res;
   endfunction

   function automatic clip_type clip32(input logic signed [63:0] v);
      clip_type res;
      res.flag = 1'b0;
      res.val  = v[31:0];
      if (v > 64'sd2147483647) begin
         res.flag = 1'b1;
         res.val  = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         res.flag = 1'b1;
         res.val  = 32'sh8000_0000;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== design/afe_ram.sv =====
// ----------------------------------------------------------------------------
// afe_ram
// Single-port RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module afe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule

`default_nettype wire

// ===== design/afe_front.sv =====
// ----------------------------------------------------------------------------
// afe_front
// Accepts request words into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module afe_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire afe_pkg::item_type req_item,
   output logic                   head_valid,
   output afe_pkg::item_type      head,
   input  wire logic              pop
);

   afe_pkg::item_type q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != 2'd0);
   assign head       = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

`default_nettype wire

// ===== design/afe_mul.sv =====
// ----------------------------------------------------------------------------
// afe_mul
// Sign-magnitude 64x64 multiply from four 32x32 partial products, optional
// right shift by 16 with truncation toward zero, saturated to +-(2^63-1).
// ----------------------------------------------------------------------------
`default_nettype none

module afe_mul (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] a,
   input  wire logic signed [63:0] b,
   input  wire logic               sh16,
   output logic                    done,
   output logic signed [63:0]      y,
   output logic                    sat
);

   localparam logic [63:0] WIDE_MAX_U = 64'h7FFF_FFFF_FFFF_FFFF;

   logic         busy_ff;
   logic [2:0]   cnt_ff;
   logic [63:0]  ua_ff, ub_ff, pp_ff;
   logic [1:0]   ppsh_ff;
   logic         neg_ff, sh_ff;
   logic [127:0] acc_ff, shifted;
   logic [63:0]  mag_w;
   logic         ovf;

   always_comb begin
      shifted = sh_ff ? (acc_ff >> 16) : acc_ff;
      ovf     = (|shifted[127:64]) || shifted[63];
      mag_w   = ovf ? WIDE_MAX_U : shifted[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         done <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 3'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd5) begin
               busy_ff <= 1'b0;
               done    <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ua_ff  <= a[63] ? 64'(-a) : a;
         ub_ff  <= b[63] ? 64'(-b) : b;
         neg_ff <= a[63] ^ b[63];
         sh_ff  <= sh16;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (cnt_ff < 3'd4) begin
            pp_ff   <= (cnt_ff[1] ? ua_ff[63:32] : ua_ff[31:0])
                     * (cnt_ff[0] ? ub_ff[63:32] : ub_ff[31:0]);
            ppsh_ff <= 2'(cnt_ff[1]) + 2'(cnt_ff[0]);
         end
         if (cnt_ff != 3'd0 && cnt_ff != 3'd5) begin
            acc_ff <= acc_ff + (128'(pp_ff) << {ppsh_ff, 5'd0});
         end
         if (cnt_ff == 3'd5) begin
            y   <= neg_ff ? -$signed(mag_w) : $signed(mag_w);
            sat <= ovf;
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/afe_div.sv =====
// ----------------------------------------------------------------------------
// afe_div
// Signed 64-bit divide by a small constant, truncating toward zero.
// The power-of-two factor is shifted out, the odd part (1, 3, 9, 15, 45) is
// divided 16 bits at a time by reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module afe_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] x,
   input  wire logic [11:0]        den,
   output logic                    done,
   output logic signed [63:0]      y
);

   logic        busy_ff, neg_ff;
   logic [2:0]  cnt_ff;
   logic [63:0] q_ff, mag_w;
   logic [5:0]  rem_ff, m_ff;
   logic [15:0] qd_ff;
   logic [28:0] rcp_ff, rcp_w;
   logic [3:0]  sh_w;
   logic [11:0] m_w;
   logic [21:0] n_w;
   logic [50:0] prod_w;

   always_comb begin
      sh_w = 4'd0;
      for (int i = 11; i >= 0; i--) begin
         if (den[i]) sh_w = 4'(i);
      end
      m_w   = den >> sh_w;
      mag_w = x[63] ? 64'(-x) : 64'(x);
      // ceil(2^28 / m)
      unique case (m_w)
         12'd3:   rcp_w = 29'd89478486;
         12'd9:   rcp_w = 29'd29826162;
         12'd15:  rcp_w = 29'd17895698;
         12'd45:  rcp_w = 29'd5965233;
         default: rcp_w = 29'd268435456;
      endcase
      n_w    = {rem_ff, q_ff[63:48]};
      prod_w = 51'(n_w) * 51'(rcp_ff);
   end

   assign y = neg_ff ? -$signed(q_ff) : $signed(q_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
         cnt_ff  <= 3'd0;
      end else begin
         done <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 3'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd7) begin
               busy_ff <= 1'b0;
               done    <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= mag_w >> sh_w;
         neg_ff <= x[63];
         rem_ff <= 6'd0;
         m_ff   <= 6'(m_w);
         rcp_ff <= rcp_w;
      end else if (busy_ff) begin
         if (!cnt_ff[0]) begin
            qd_ff <= prod_w[43:28];
         end else begin
            rem_ff <= 6'(n_w - 22'(qd_ff) * 22'(m_ff));
            q_ff   <= {q_ff[47:0], qd_ff};
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/afe_back.sv =====
// ----------------------------------------------------------------------------
// afe_back
// Executes queued words: table loads, and field evaluation through the
// interpolation, stencil and series steps on a shared multiplier and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module afe_back #(
   parameter int MAX_NODES = 1024,
   localparam int AW = $clog2(MAX_NODES)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire afe_pkg::cfg_type   cfg,
   input  wire logic               head_valid,
   input  wire afe_pkg::item_type  head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_axial_field,
   output logic signed [31:0]      rsp_radial_field,
   output logic                    rsp_saturated
);

   afe_pkg::back_state_type st_ff, state_in;

   logic               we, in_range, is_eval, rsp_load, last_scale;
   logic [AW-1:0]      addr, cell_ff;
   logic [31:0]        rdata;
   logic [3:0]         cnt_ff, t_ff;
   logic [2:0]         k_ff, order_ff, ki;
   logic [16:0]        n_ff, nc;
   logic signed [32:0] d_ff, cell0, cell_c;
   logic signed [64:0] p_ff;
   logic signed [48:0] u16;
   logic signed [49:0] frac_w;
   logic signed [17:0] hi_lim;
   logic signed [63:0] frac_ff, x_ff, bz_ff, br_ff, r_ff, term;
   logic signed [31:0] s_ff [8];
   logic signed [63:0] v_ff [7];
   logic               flag_ff;

   logic               mul_start, mul_sh, mul_done, mul_sat;
   logic signed [63:0] mul_a, mul_b, mul_y;
   logic               div_start, div_done;
   logic signed [63:0] div_x, div_y;
   logic [11:0]        div_den;

   afe_pkg::sat_type   ip_sum, st_sum, term_sum;
   afe_pkg::clip_type  ax_clip, ra_clip;

   afe_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_ram (
      .clock (clock), .we (we), .addr (addr), .wdata (head.sample_value), .rdata (rdata)
   );

   afe_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start), .a (mul_a), .b (mul_b),
      .sh16 (mul_sh), .done (mul_done), .y (mul_y), .sat (mul_sat)
   );

   afe_div u_div (
      .clock (clock), .reset (reset), .start (div_start), .x (div_x), .den (div_den),
      .done (div_done), .y (div_y)
   );

   always_comb begin
      in_range = 17'(head.sample_index) < 17'(MAX_NODES);
      is_eval  = head.kind == afe_pkg::KIND_EVAL;
      we       = (st_ff == afe_pkg::B_IDLE) && head_valid && !is_eval && in_range;
      addr     = (st_ff == afe_pkg::B_IDLE) ? AW'(head.sample_index)
               : AW'(cell_ff + AW'(cnt_ff[2:0]) - AW'(3));
      nc       = 17'(cfg.nodes);
      if (nc < 17'd8) begin
         nc = 17'd8;
      end else if (nc > 17'(MAX_NODES)) begin
         nc = 17'(MAX_NODES);
      end
      u16    = p_ff[64:16];
      cell0  = u16[48:16];
      hi_lim = $signed({1'b0, n_ff}) - 18'sd5;
      if (cell0 < 33'sd3) begin
         cell_c = 33'sd3;
      end else if (cell0 > hi_lim) begin
         cell_c = 33'(hi_lim);
      end else begin
         cell_c = cell0;
      end
      frac_w     = 50'(u16) - $signed(50'({cell_c, 16'd0}));
      ki         = k_ff - 3'd1;
      last_scale = t_ff == ({k_ff, 1'b0} - 4'd1);
      ip_sum     = afe_pkg::add_sat(64'(s_ff[0]), mul_y);
      st_sum     = afe_pkg::add_sat(x_ff, mul_y);
      term       = afe_pkg::NEG_TERM[ki] ? -div_y : div_y;
      term_sum   = afe_pkg::add_sat(k_ff[0] ? br_ff : bz_ff, term);
      ax_clip    = afe_pkg::clip32(bz_ff);
      ra_clip    = afe_pkg::clip32(br_ff);
      rsp_load   = !rsp_valid || !rsp_stall;
   end

   always_comb begin
      state_in  = st_ff;
      pop       = 1'b0;
      mul_start = 1'b0;
      mul_sh    = 1'b1;
      mul_a     = x_ff;
      mul_b     = (t_ff < {1'b0, k_ff}) ? 64'($signed({1'b0, cfg.inv_step})) : r_ff;
      div_start = 1'b0;
      div_x     = st_sum.val;
      div_den   = afe_pkg::STENCIL_DEN[ki];
      unique case (st_ff)
         afe_pkg::B_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               if (is_eval) state_in = afe_pkg::B_POS;
            end
         end
         afe_pkg::B_POS:  state_in = afe_pkg::B_CELL;
         afe_pkg::B_CELL: state_in = afe_pkg::B_READ;
         afe_pkg::B_READ: begin
            if (cnt_ff == 4'd8) state_in = afe_pkg::B_IP;
         end
         afe_pkg::B_IP: begin
            mul_start = 1'b1;
            mul_a     = frac_ff;
            mul_b     = 64'(s_ff[1]) - 64'(s_ff[0]);
            state_in  = afe_pkg::B_IPW;
         end
         afe_pkg::B_IPW: begin
            if (mul_done) state_in = (cnt_ff == 4'd6) ? afe_pkg::B_K0 : afe_pkg::B_IP;
         end
         afe_pkg::B_K0: begin
            state_in = (order_ff == 3'd0) ? afe_pkg::B_FIN : afe_pkg::B_ST;
         end
         afe_pkg::B_ST: begin
            mul_start = 1'b1;
            mul_sh    = 1'b0;
            mul_a     = 64'(afe_pkg::STENCIL[ki][cnt_ff[2:0]]);
            mul_b     = v_ff[0];
            state_in  = afe_pkg::B_STW;
         end
         afe_pkg::B_STW: begin
            if (mul_done) begin
               if (cnt_ff == 4'd6) begin
                  div_start = 1'b1;
                  state_in  = afe_pkg::B_DENW;
               end else begin
                  state_in = afe_pkg::B_ST;
               end
            end
         end
         afe_pkg::B_DENW: begin
            if (div_done) state_in = afe_pkg::B_SC;
         end
         afe_pkg::B_SC: begin
            mul_start = 1'b1;
            state_in  = afe_pkg::B_SCW;
         end
         afe_pkg::B_SCW: begin
            div_x   = mul_y;
            div_den = afe_pkg::SERIES_DIV[ki];
            if (mul_done) begin
               if (last_scale) begin
                  div_start = 1'b1;
                  state_in  = afe_pkg::B_SDW;
               end else begin
                  state_in = afe_pkg::B_SC;
               end
            end
         end
         afe_pkg::B_SDW: begin
            if (div_done) state_in = (k_ff == order_ff) ? afe_pkg::B_FIN : afe_pkg::B_ST;
         end
         afe_pkg::B_FIN: begin
            if (rsp_load) state_in = afe_pkg::B_IDLE;
         end
         default: state_in = afe_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= afe_pkg::B_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         st_ff <= state_in;
         if (st_ff == afe_pkg::B_FIN && rsp_load) begin
            rsp_valid <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (st_ff)
         afe_pkg::B_IDLE: begin
            d_ff     <= 33'(head.axial_pos) - 33'(cfg.origin);
            r_ff     <= 64'(head.radial_pos);
            flag_ff  <= 1'b0;
            order_ff <= (cfg.order == 3'd7) ? 3'd6 : cfg.order;
            n_ff     <= nc;
         end
         afe_pkg::B_POS: p_ff <= 65'(d_ff * $signed({1'b0, cfg.inv_step}));
         afe_pkg::B_CELL: begin
            cell_ff <= AW'(cell_c);
            frac_ff <= 64'(frac_w);
            cnt_ff  <= 4'd0;
         end
         afe_pkg::B_READ: begin
            cnt_ff <= (cnt_ff == 4'd8) ? 4'd0 : cnt_ff + 4'd1;
            if (cnt_ff != 4'd0) begin
               for (int i = 0; i < 7; i++) s_ff[i] <= s_ff[i+1];
               s_ff[7] <= rdata;
            end
         end
         afe_pkg::B_IPW: begin
            if (mul_done) begin
               for (int i = 0; i < 6; i++) v_ff[i] <= v_ff[i+1];
               v_ff[6] <= ip_sum.val;
               for (int i = 0; i < 7; i++) s_ff[i] <= s_ff[i+1];
               flag_ff <= flag_ff | mul_sat | ip_sum.flag;
               cnt_ff  <= cnt_ff + 4'd1;
            end
         end
         afe_pkg::B_K0: begin
            bz_ff  <= v_ff[3];
            br_ff  <= '0;
            k_ff   <= 3'd1;
            cnt_ff <= 4'd0;
            x_ff   <= '0;
         end
         afe_pkg::B_STW: begin
            if (mul_done) begin
               x_ff <= st_sum.val;
               for (int i = 0; i < 6; i++) v_ff[i] <= v_ff[i+1];
               v_ff[6] <= v_ff[0];
               flag_ff <= flag_ff | mul_sat | st_sum.flag;
               cnt_ff  <= cnt_ff + 4'd1;
            end
         end
         afe_pkg::B_DENW: begin
            if (div_done) begin
               x_ff <= div_y;
               t_ff <= 4'd0;
            end
         end
         afe_pkg::B_SCW: begin
            if (mul_done) begin
               x_ff    <= mul_y;
               flag_ff <= flag_ff | mul_sat;
               t_ff    <= t_ff + 4'd1;
            end
         end
         afe_pkg::B_SDW: begin
            if (div_done) begin
               if (k_ff[0]) br_ff <= term_sum.val;
               else         bz_ff <= term_sum.val;
               flag_ff <= flag_ff | term_sum.flag;
               k_ff    <= k_ff + 3'd1;
               cnt_ff  <= 4'd0;
               x_ff    <= '0;
            end
         end
         afe_pkg::B_FIN: begin
            if (rsp_load) begin
               rsp_axial_field  <= ax_clip.val;
               rsp_radial_field <= ra_clip.val;
               rsp_saturated    <= flag_ff | ax_clip.flag | ra_clip.flag;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/axisymmetric_field_fdm_expansion.sv =====
// ----------------------------------------------------------------------------
// axisymmetric_field_fdm_expansion
// Load words write the sample table directly; evaluate words use the single
// shared 32x32 multiplier, the shared divider and the one RAM port.
// Words are handled one at a time; a two-word queue and the output register
// keep both sides decoupled. Synchronous reset restores register defaults;
// the sample table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module axisymmetric_field_fdm_expansion #(
   parameter int MAX_NODES = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_kind,
   input  wire logic [9:0]         req_sample_index,
   input  wire logic signed [31:0] req_sample_value,
   input  wire logic signed [31:0] req_axial_pos,
   input  wire logic signed [31:0] req_radial_pos,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_axial_field,
   output logic signed [31:0]      rsp_radial_field,
   output logic                    rsp_saturated,
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);

   afe_pkg::cfg_type  cfg_ff;
   afe_pkg::item_type req_item, head;
   logic              head_valid, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin   <= 32'sd0;
         cfg_ff.inv_step <= 32'd65536;
         cfg_ff.order    <= 3'd6;
         cfg_ff.nodes    <= 11'd1024;
      end else if (csr_write) begin
         unique case (csr_index)
            afe_pkg::CSR_ORIGIN:  cfg_ff.origin   <= csr_data;
            afe_pkg::CSR_INVSTEP: cfg_ff.inv_step <= csr_data;
            afe_pkg::CSR_ORDER:   cfg_ff.order    <= csr_data[2:0];
            afe_pkg::CSR_NODES:   cfg_ff.nodes    <= csr_data[10:0];
         endcase
      end
   end

   always_comb begin
      req_item.kind         = req_kind;
      req_item.sample_index = req_sample_index;
      req_item.sample_value = req_sample_value;
      req_item.axial_pos    = req_axial_pos;
      req_item.radial_pos   = req_radial_pos;
   end

   afe_front u_front (
      .clock (clock), .reset (reset), .req_valid (req_valid), .req_stall (req_stall),
      .req_item (req_item), .head_valid (head_valid), .head (head), .pop (pop)
   );

   afe_back #(.MAX_NODES(MAX_NODES)) u_back (
      .clock (clock), .reset (reset), .cfg (cfg_ff), .head_valid (head_valid),
      .head (head), .pop (pop), .rsp_valid (rsp_valid), .rsp_stall (rsp_stall),
      .rsp_axial_field (rsp_axial_field), .rsp_radial_field (rsp_radial_field),
      .rsp_saturated (rsp_saturated)
   );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the off-axis field expansion block. The sample table
// is filled, then directed and random load/evaluate words are sent under
// several register settings, with random gaps and output stalls. A scoreboard
// predicts every evaluate result and checks it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

class field_scoreboard;
   typedef struct {
      logic signed [31:0] axial;
      logic signed [31:0] radial;
      logic               sat;
   } field_type;

   longint            samples [1024];
   longint            origin;
   logic [31:0]       inv_step;
   logic [2:0]        order;
   logic [10:0]       nodes;
   logic              clip;
   field_type         pending [$];
   int                errors, loads, evals, sat_seen;

   function new();
      origin = 0; inv_step = 32'd65536; order = 3'd6; nodes = 11'd1024;
      foreach (samples[i]) samples[i] = 0;
   endfunction

   function longint mul_shift(longint a, longint b, int sh);
      logic [63:0]  ua, ub;
      logic [127:0] p;
      logic         neg;
      ua = a < 0 ? 64'(-a) : 64'(a);
      ub = b < 0 ? 64'(-b) : 64'(b);
      neg = (a < 0) != (b < 0);
      p = ({64'd0, ua} * {64'd0, ub}) >> sh;
      if (p > 128'(afe_pkg::WIDE_MAX)) begin
         clip = 1'b1;
         p = 128'(afe_pkg::WIDE_MAX);
      end
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function longint add_wide(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(afe_pkg::WIDE_MAX)) begin
         clip = 1'b1;
         return afe_pkg::WIDE_MAX;
      end
      if (s < -65'(afe_pkg::WIDE_MAX)) begin
         clip = 1'b1;
         return -afe_pkg::WIDE_MAX;
      end
      return longint'(s[63:0]);
   endfunction

   function logic signed [31:0] clip_out(longint v);
      if (v > 64'sd2147483647) begin
         clip = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         clip = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function field_type expand(logic signed [31:0] z, logic signed [31:0] r_in);
      longint      n, d, u16, cell_idx, frac, x, bz, br, r, den;
      longint      v [7];
      logic [63:0] m, t;
      int          ord;
      field_type   f;
      clip = 1'b0;
      n = nodes < 8 ? 8 : (nodes > 1024 ? 1024 : longint'(nodes));
      ord = order > 6 ? 6 : int'(order);
      d = longint'(z) - origin;
      m = (d < 0 ? 64'(-d) : 64'(d)) * {32'd0, inv_step};
      if (d < 0) u16 = -longint'((m + 64'hFFFF) >> 16);
      else u16 = longint'(m >> 16);
      if (u16 < 0) begin
         t = 64'(-u16);
         cell_idx = -longint'((t + 64'hFFFF) >> 16);
      end else cell_idx = u16 >>> 16;
      if (cell_idx < 3) cell_idx = 3;
      if (cell_idx > n - 5) cell_idx = n - 5;
      frac = u16 - cell_idx * 65536;
      for (int a = 0; a < 7; a++)
         v[a] = add_wide(samples[cell_idx + a - 3],
                         mul_shift(frac, samples[cell_idx + a - 2]
                                         - samples[cell_idx + a - 3], 16));
      bz = v[3];
      br = 0;
      r = longint'(r_in);
      for (int k = 1; k <= ord; k++) begin
         x = 0;
         for (int a = 0; a < 7; a++)
            x = add_wide(x, mul_shift(longint'(afe_pkg::STENCIL[k-1][a]), v[a], 0));
         den = longint'(afe_pkg::STENCIL_DEN[k-1]);
         x = x / den;
         for (int i = 0; i < k; i++) x = mul_shift(x, longint'({32'd0, inv_step}), 16);
         for (int i = 0; i < k; i++) x = mul_shift(x, r, 16);
         den = longint'(afe_pkg::SERIES_DIV[k-1]);
         x = x / den;
         if (afe_pkg::NEG_TERM[k-1]) x = -x;
         if (k % 2 == 1) br = add_wide(br, x);
         else bz = add_wide(bz, x);
      end
      f.axial = clip_out(bz);
      f.radial = clip_out(br);
      f.sat = clip;
      return f;
   endfunction

   function void note_word(afe_pkg::item_type it);
      field_type f;
      if (it.kind == afe_pkg::KIND_LOAD) begin
         samples[it.sample_index] = longint'(it.sample_value);
         loads++;
      end else begin
         f = expand(it.axial_pos, it.radial_pos);
         pending.push_back(f);
         evals++;
      end
   endfunction

   function void check_word(logic signed [31:0] az, logic signed [31:0] rz, logic s);
      field_type f;
      if (pending.size() == 0) begin
         $error("unexpected result word axial=%0d radial=%0d", az, rz);
         errors++;
         return;
      end
      f = pending.pop_front();
      if (f.sat) sat_seen++;
      if (az !== f.axial) begin
         $error("axial_field expected %0d got %0d", f.axial, az);
         errors++;
      end
      if (rz !== f.radial) begin
         $error("radial_field expected %0d got %0d", f.radial, rz);
         errors++;
      end
      if (s !== f.sat) begin
         $error("saturated expected %0d got %0d", f.sat, s);
         errors++;
      end
   endfunction
endclass

module tb;

   localparam int WATCHDOG = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_kind = afe_pkg::KIND_LOAD;
   logic [9:0]         req_sample_index = '0;
   logic signed [31:0] req_sample_value = '0;
   logic signed [31:0] req_axial_pos = '0;
   logic signed [31:0] req_radial_pos = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_axial_field;
   logic signed [31:0] rsp_radial_field;
   logic               rsp_saturated;
   logic               csr_write = 1'b0;
   logic [1:0]         csr_index = afe_pkg::CSR_ORIGIN;
   logic [31:0]        csr_data = '0;

   field_scoreboard sb = new();
   int              idle_cycles = 0;
   int              stall_left = 0;
   int              phases = 0;

   axisymmetric_field_fdm_expansion u_top (
      .clock, .reset, .req_valid, .req_stall, .req_kind, .req_sample_index,
      .req_sample_value, .req_axial_pos, .req_radial_pos, .rsp_valid, .rsp_stall,
      .rsp_axial_field, .rsp_radial_field, .rsp_saturated, .csr_write, .csr_index,
      .csr_data
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         afe_pkg::item_type it;
         it.kind = req_kind;
         it.sample_index = req_sample_index;
         it.sample_value = req_sample_value;
         it.axial_pos = req_axial_pos;
         it.radial_pos = req_radial_pos;
         sb.note_word(it);
      end
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(rsp_axial_field, rsp_radial_field, rsp_saturated);
   end

   // output stall in random stretches, each stretch either stalled or flowing
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_word(logic kind, logic [9:0] idx, logic [31:0] val,
                            logic [31:0] z, logic [31:0] r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_sample_index <= idx;
      req_sample_value <= val;
      req_axial_pos <= z;
      req_radial_pos <= r;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic set_regs(logic [31:0] org, logic [31:0] inv, logic [2:0] ord,
                           logic [10:0] n);
      wait_drained();
      repeat (40) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_write <= 1'b1;
         case (i)
            0: begin csr_index <= afe_pkg::CSR_ORIGIN; csr_data <= org; end
            1: begin csr_index <= afe_pkg::CSR_INVSTEP; csr_data <= inv; end
            2: begin csr_index <= afe_pkg::CSR_ORDER; csr_data <= 32'(ord); end
            default: begin csr_index <= afe_pkg::CSR_NODES; csr_data <= 32'(n); end
         endcase
         @(posedge clock);
      end
      csr_write <= 1'b0;
      sb.origin = longint'($signed(org));
      sb.inv_step = inv;
      sb.order = ord;
      sb.nodes = n;
      phases++;
   endtask

   task automatic random_word();
      logic [31:0] val, z, r;
      longint      span, n;
      if ($urandom_range(0, 99) < 40) begin
         val = ($urandom_range(0, 9) == 0) ? $urandom()
               : 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
         send_word(afe_pkg::KIND_LOAD, 10'($urandom_range(0, 1023)), val,
                   $urandom(), $urandom());
      end else begin
         n = sb.nodes < 8 ? 8 : (sb.nodes > 1024 ? 1024 : longint'(sb.nodes));
         if (sb.inv_step == 0) span = 64'h7FFF_FFFF;
         else span = ((n + 4) << 32) / longint'({32'd0, sb.inv_step});
         if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
         if ($urandom_range(0, 9) < 7)
            z = 32'(sb.origin + longint'($urandom_range(0, 32'(span))) - span / 16);
         else
            z = $urandom();
         r = ($urandom_range(0, 9) < 7)
             ? 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000)
             : $urandom();
         send_word(afe_pkg::KIND_EVAL, 10'($urandom()), $urandom(), z, r);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the whole table so no evaluate reads an unwritten entry
      for (int i = 0; i < 1024; i++)
         send_word(afe_pkg::KIND_LOAD, 10'(i),
                   32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000),
                   $urandom(), $urandom());

      // directed: extreme samples, edge cells, extreme positions and radii
      send_word(afe_pkg::KIND_LOAD, 10'd500, 32'h7FFF_FFFF, '0, '0);
      send_word(afe_pkg::KIND_LOAD, 10'd501, 32'h8000_0000, '0, '0);
      send_word(afe_pkg::KIND_LOAD, 10'd502, 32'h7FFF_FFFF, '0, '0);
      send_word(afe_pkg::KIND_LOAD, 10'd1023, 32'h8000_0000, '0, '0);
      send_word(afe_pkg::KIND_LOAD, 10'd0, 32'h7FFF_FFFF, '0, '0);
      send_word(afe_pkg::KIND_EVAL, '0, '0, 32'h01F5_8000, 32'h0001_0000);
      send_word(afe_pkg::KIND_EVAL, '0, '0, 32'h01F4_0000, 32'h0000_0000);
      send_word(afe_pkg::KIND_EVAL, '0, '0, 32'h01F6_4000, 32'h7FFF_FFFF);
      send_word(afe_pkg::KIND_EVAL, '0, '0, 32'h01F6_4000, 32'h8000_0000);
      send_word(afe_pkg::KIND_EVAL, '0, '0, 32'h8000_0000, 32'h0000_8000);
      send_word(afe_pkg::KIND_EVAL, '0, '0, 32'h7FFF_FFFF, 32'hFFFF_8000);
      send_word(afe_pkg::KIND_EVAL, '0, '0, 32'h0000_0000, 32'h0002_0000);
      send_word(afe_pkg::KIND_EVAL, '0, '0, 32'h03FF_FFFF, 32'h0002_0000);
      send_word(afe_pkg::KIND_EVAL, '0, '0, 32'h0100_0000, 32'hFFFF_FFFF);
      send_word(afe_pkg::KIND_LOAD, 10'd500, 32'h0100_0000, '0, '0);
      send_word(afe_pkg::KIND_LOAD, 10'd501, 32'hFF00_0000, '0, '0);
      send_word(afe_pkg::KIND_LOAD, 10'd502, 32'h0000_0000, '0, '0);
      send_word(afe_pkg::KIND_LOAD, 10'd1023, 32'h0000_0001, '0, '0);
      send_word(afe_pkg::KIND_LOAD, 10'd0, 32'hFFFF_FFFF, '0, '0);

      for (int p = 0; p < 7; p++) begin
         case (p)
            0: set_regs(32'h0000_0000, 32'd65536, 3'd6, 11'd1024);
            1: set_regs(32'h8000_0000, 32'd1, 3'd0, 11'd8);
            2: set_regs(32'h7FFF_FFFF, 32'hFFFF_FFFF, 3'd7, 11'd2047);
            3: set_regs(32'h0010_0000, 32'h0002_0000, 3'd3, 11'd100);
            4: set_regs(32'hFF00_0000, 32'h0000_8000, 3'd5, 11'd0);
            5: set_regs(32'h0000_0000, 32'd0, 3'd1, 11'd9);
            default: set_regs(32'hFFFF_0000, 32'h0004_0000, 3'd2, 11'd1024);
         endcase
         for (int i = 0; i < 62; i++) begin
            if (p == 3 && i == 30) wait_drained();
            random_word();
         end
      end

      wait_drained();
      repeat (60) @(posedge clock);
      $display("tb: %0d loads, %0d evaluates over %0d register settings, %0d saturated",
               sb.loads, sb.evals, phases, sb.sat_seen);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

`default_nettype wire

// ===== files.f =====
design/afe_pkg.sv
design/afe_ram.sv
design/afe_front.sv
design/afe_mul.sv
design/afe_div.sv
design/afe_back.sv
design/axisymmetric_field_fdm_expansion.sv
bench/tb.sv
